// ===== rtl/core/gct_pkg.sv =====
// ----------------------------------------------------------------------------
// gct_pkg
// Shared constants and types for the greedy corner tracker.
// ----------------------------------------------------------------------------
package gct_pkg;

    // Default coordinate width (signed Q12.4)
    localparam int COORD_BITS_DEF = 16;
    // Corners per quad, and bits to number a slot
    localparam int NUM_CORNERS    = 4;
    localparam int SLOT_BITS      = $clog2(NUM_CORNERS);
    // Depth of the request queue between front and back
    localparam int QUEUE_DEPTH    = 2;

    // Control word that travels with the distance stage
    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic [SLOT_BITS-1:0] slot;
    } t_stage_ctl;

endpackage

// ===== rtl/core/gct_front.sv =====
// ----------------------------------------------------------------------------
// gct_front
// Accepts requests, tags each with a first-frame flag and queues them
// for the matching engine.
// ----------------------------------------------------------------------------
module gct_front #(
    parameter int COORD_BITS = gct_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic [gct_pkg::NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] i_data,
    output logic o_head_valid,
    output logic o_head_first,
    output logic [gct_pkg::NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] o_head_data,
    input  logic i_pop
);
    import gct_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] r_data [QUEUE_DEPTH];
    logic                r_first [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                r_has_hist;
    logic                push;
    logic                pop;

    assign o_ready      = (r_count != CNT_BITS'(QUEUE_DEPTH));
    assign push         = i_valid && o_ready;
    assign pop          = i_pop && o_head_valid;
    assign o_head_valid = (r_count != '0);
    assign o_head_data  = r_data[r_rd_ptr];
    assign o_head_first = r_first[r_rd_ptr];

    // Queue storage; first request after reset is marked pass-through
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wr_ptr]  <= i_data;
            r_first[r_wr_ptr] <= !r_has_hist;
        end
    end

    // Pointers, fill count and history flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
            r_has_hist <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr   <= (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
                r_has_hist <= 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/gct_dist.sv =====
// ----------------------------------------------------------------------------
// gct_dist
// Distance stage: one tracked slot per cycle while a request is queued and no
// stall holds it, squares of the x and y gaps from that slot to all four detected corners.
// ----------------------------------------------------------------------------
module gct_dist #(
    parameter int COORD_BITS = gct_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_head_valid,
    input  logic i_head_first,
    input  logic [gct_pkg::NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] i_head_data,
    output logic o_pop,
    input  logic i_stall,
    input  logic [gct_pkg::NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] i_tracked,
    output gct_pkg::t_stage_ctl o_ctl,
    output logic [gct_pkg::NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] o_pts,
    output logic [gct_pkg::NUM_CORNERS-1:0][2*COORD_BITS+1:0] o_sqx,
    output logic [gct_pkg::NUM_CORNERS-1:0][2*COORD_BITS+1:0] o_sqy
);
    import gct_pkg::*;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS + 2;

    logic [SLOT_BITS-1:0]                        r_slot;
    t_stage_ctl                                  r_ctl;
    logic [NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] r_pts;
    logic [NUM_CORNERS-1:0][SQ_W-1:0]            r_sqx;
    logic [NUM_CORNERS-1:0][SQ_W-1:0]            r_sqy;
    logic [NUM_CORNERS-1:0][SQ_W-1:0]            n_sqx;
    logic [NUM_CORNERS-1:0][SQ_W-1:0]            n_sqy;
    logic [1:0][COORD_BITS-1:0]                  ref_pt;
    logic signed [DIFF_W-1:0]                    dx;
    logic signed [DIFF_W-1:0]                    dy;
    logic [DIFF_W-1:0]                           adx;
    logic [DIFF_W-1:0]                           ady;

    assign ref_pt = i_tracked[r_slot];
    assign o_pop  = i_head_valid && !i_stall && (r_slot == SLOT_BITS'(NUM_CORNERS - 1));

    // Exact squared gaps, sign-extended by one bit so no overflow
    always_comb begin
        n_sqx = '0;
        n_sqy = '0;
        dx    = '0;
        dy    = '0;
        adx   = '0;
        ady   = '0;
        for (int j = 0; j < NUM_CORNERS; j++) begin
            dx  = $signed({ref_pt[0][COORD_BITS-1], ref_pt[0]})
                - $signed({i_head_data[j][0][COORD_BITS-1], i_head_data[j][0]});
            dy  = $signed({ref_pt[1][COORD_BITS-1], ref_pt[1]})
                - $signed({i_head_data[j][1][COORD_BITS-1], i_head_data[j][1]});
            adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
            ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
            n_sqx[j] = SQ_W'(adx) * SQ_W'(adx);
            n_sqy[j] = SQ_W'(ady) * SQ_W'(ady);
        end
    end

    // Slot counter and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_ctl  <= '0;
        end else if (!i_stall) begin
            r_ctl.valid <= i_head_valid;
            r_ctl.first <= i_head_first;
            r_ctl.slot  <= r_slot;
            if (i_head_valid) begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (!i_stall && i_head_valid) begin
            r_pts <= i_head_data;
            r_sqx <= n_sqx;
            r_sqy <= n_sqy;
        end
    end

    assign o_ctl = r_ctl;
    assign o_pts = r_pts;
    assign o_sqx = r_sqx;
    assign o_sqy = r_sqy;

endmodule

// ===== rtl/core/gct_select.sv =====
// ----------------------------------------------------------------------------
// gct_select
// Select stage: picks the nearest unused corner for the slot (the same-index
// corner on a first frame), updates the tracked set and assembles the result in the output register.
// ----------------------------------------------------------------------------
module gct_select #(
    parameter int COORD_BITS = gct_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  gct_pkg::t_stage_ctl i_ctl,
    input  logic [gct_pkg::NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] i_pts,
    input  logic [gct_pkg::NUM_CORNERS-1:0][2*COORD_BITS+1:0] i_sqx,
    input  logic [gct_pkg::NUM_CORNERS-1:0][2*COORD_BITS+1:0] i_sqy,
    output logic o_stall,
    output logic [gct_pkg::NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] o_tracked,
    output logic o_m_valid,
    input  logic i_m_ready,
    output logic [gct_pkg::NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] o_m_data,
    output logic o_m_first
);
    import gct_pkg::*;

    localparam int SUM_W = 2 * COORD_BITS + 3;

    logic [NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] r_tracked;
    logic [NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] r_res;
    logic [NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] n_res;
    logic [NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] r_m_data;
    logic                                        r_m_valid;
    logic                                        r_m_first;
    logic [NUM_CORNERS-1:0]                      r_used;
    logic [NUM_CORNERS-1:0]                      used_eff;
    logic [NUM_CORNERS-1:0][SUM_W-1:0]           sum_d;
    logic [SUM_W-1:0]                            best_d;
    logic [SLOT_BITS-1:0]                        best;
    logic [SLOT_BITS-1:0]                        pick_idx;
    logic                                        found;
    logic [1:0][COORD_BITS-1:0]                  pick;
    logic                                        last;
    logic                                        advance;

    assign used_eff = (i_ctl.slot == '0) ? '0 : r_used;
    assign last     = i_ctl.valid && (i_ctl.slot == SLOT_BITS'(NUM_CORNERS - 1));
    assign o_stall  = last && r_m_valid && !i_m_ready;
    assign advance  = i_ctl.valid && !o_stall;

    // Nearest unused corner, lowest index wins a tie
    always_comb begin
        best   = '0;
        best_d = '0;
        found  = 1'b0;
        for (int j = 0; j < NUM_CORNERS; j++) begin
            sum_d[j] = SUM_W'(i_sqx[j]) + SUM_W'(i_sqy[j]);
            if (!used_eff[j] && (!found || sum_d[j] < best_d)) begin
                best   = SLOT_BITS'(j);
                best_d = sum_d[j];
                found  = 1'b1;
            end
        end
        pick_idx = i_ctl.first ? i_ctl.slot : best;
        pick     = i_pts[pick_idx];
        n_res    = r_res;
        n_res[i_ctl.slot] = pick;
    end

    // Tracked set, partial result and output payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_tracked[i_ctl.slot] <= pick;
            r_res                 <= n_res;
            if (last) begin
                r_m_data  <= n_res;
                r_m_first <= i_ctl.first;
            end
        end
    end

    // Used-corner mask and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_used <= last ? '0 : (used_eff | (NUM_CORNERS'(1) << pick_idx));
            end
            if (advance && last) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_tracked = r_tracked;
    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;
    assign o_m_first = r_m_first;

endmodule

// ===== rtl/core/greedy_corner_tracker.sv =====
// ----------------------------------------------------------------------------
// greedy_corner_tracker
// Each request passes through the request queue, the distance stage register
// and the select stage output register; one tracked slot per cycle moves through
// the distance and select stages unless the result stream stalls them.
// Reset: synchronous, active low; clears queue, history flag and output valid.
// Keeps the four corners of a quad in a stable slot order across frames.
// ----------------------------------------------------------------------------
module greedy_corner_tracker #(
    parameter int COORD_BITS = gct_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Request stream
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // tdata, low bit up: in_x0, in_y0, in_x1, in_y1, in_x2, in_y2, in_x3, in_y3
    input  logic [2*gct_pkg::NUM_CORNERS*COORD_BITS-1:0] i_s_tdata,
    // Result stream
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // tdata, low bit up: out_x0, out_y0, out_x1, out_y1, out_x2, out_y2, out_x3, out_y3
    output logic [2*gct_pkg::NUM_CORNERS*COORD_BITS-1:0] o_m_tdata,
    // tuser: first_frame
    output logic [0:0] o_m_tuser
);
    import gct_pkg::*;

    logic [NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] s_data;
    logic [NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] head_data;
    logic [NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] pts;
    logic [NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] tracked;
    logic [NUM_CORNERS-1:0][1:0][COORD_BITS-1:0] m_data;
    logic [NUM_CORNERS-1:0][2*COORD_BITS+1:0]    sqx;
    logic [NUM_CORNERS-1:0][2*COORD_BITS+1:0]    sqy;
    logic                                        head_valid;
    logic                                        head_first;
    logic                                        pop;
    logic                                        stall;
    logic                                        m_first;
    t_stage_ctl                                  ctl;

    assign s_data       = i_s_tdata;
    assign o_m_tdata    = m_data;
    assign o_m_tuser[0] = m_first;

    gct_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_data       (s_data),
        .o_head_valid (head_valid),
        .o_head_first (head_first),
        .o_head_data  (head_data),
        .i_pop        (pop)
    );

    gct_dist #(.COORD_BITS(COORD_BITS)) u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_first (head_first),
        .i_head_data  (head_data),
        .o_pop        (pop),
        .i_stall      (stall),
        .i_tracked    (tracked),
        .o_ctl        (ctl),
        .o_pts        (pts),
        .o_sqx        (sqx),
        .o_sqy        (sqy)
    );

    gct_select #(.COORD_BITS(COORD_BITS)) u_select (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_pts     (pts),
        .i_sqx     (sqx),
        .i_sqy     (sqy),
        .o_stall   (stall),
        .o_tracked (tracked),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .o_m_data  (m_data),
        .o_m_first (m_first)
    );

endmodule
